/* rtl/assert_macros.svh */
// assertion macros shared by the rtl of the edge finder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define RMDEF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define RMDEF_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define RMDEF_ASSERT(lbl, prop, msg)

`define RMDEF_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

/* rtl/rmdef_pkg.sv */
// shared types and constants of the red mask door edge finder
`timescale 1ns / 1ps

package rmdef_pkg;

    localparam int POS_W       = 12;
    localparam int PIX_W       = 8;
    localparam int COUNT_W     = 5;
    localparam int GREEN_SUM_W = 18;
    localparam int CFG_IDX_W   = 2;

    localparam int BAND_START_ROW = 50;
    localparam int EDGE_THRESHOLD = 10;

    localparam int DEF_SCAN_COLUMNS = 50;
    localparam int DEF_BAND_ROWS    = 20;
    localparam int DEF_CORNER_ROWS  = 30;
    localparam int DEF_CORNER_COLS  = 20;

    localparam logic [POS_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [POS_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // where a pixel falls in the frame
    typedef struct packed {
        logic left_band;
        logic right_band;
        logic corner_left;
        logic corner_right;
        logic row_end;
        logic frame_end;
    } pix_flags_t;

endpackage

/* rtl/rmdef_count_mem.sv */
// band count memory with per-entry valid bits and write-to-read bypass
`timescale 1ns / 1ps

module rmdef_count_mem
    import rmdef_pkg::*;
#(
    parameter int DEPTH  = DEF_SCAN_COLUMNS,
    parameter int ADDR_W = 6,
    parameter int DATA_W = COUNT_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              clear,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // clearing the valid bits empties the whole table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (clear)
            begin
                rd_data_reg <= '0;
            end
            else if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem_reg[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/rmdef_raster_pos.sv */
// raster position counters and per-pixel region decode
`timescale 1ns / 1ps

module rmdef_raster_pos
    import rmdef_pkg::*;
#(
    parameter int SCAN_COLUMNS = DEF_SCAN_COLUMNS,
    parameter int BAND_ROWS    = DEF_BAND_ROWS,
    parameter int CORNER_ROWS  = DEF_CORNER_ROWS,
    parameter int CORNER_COLS  = DEF_CORNER_COLS,
    parameter int IDX_W        = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [POS_W-1:0] frame_width,
    input  logic [POS_W-1:0] frame_height,
    output pix_flags_t       flags,
    output logic [POS_W-1:0] column_pos,
    output logic [POS_W-1:0] row_pos,
    output logic [IDX_W-1:0] left_index,
    output logic [IDX_W-1:0] right_index
);

    localparam logic [POS_W:0] SCAN_EXT    = (POS_W+1)'(SCAN_COLUMNS);
    localparam logic [POS_W:0] CORNER_C    = (POS_W+1)'(CORNER_COLS);
    localparam logic [POS_W:0] CORNER_R    = (POS_W+1)'(CORNER_ROWS);
    localparam logic [POS_W:0] BAND_LO     = (POS_W+1)'(BAND_START_ROW);
    localparam logic [POS_W:0] BAND_HI     = (POS_W+1)'(BAND_START_ROW + BAND_ROWS);
    localparam logic [POS_W:0] ONE_EXT     = (POS_W+1)'(1);

    logic [POS_W-1:0] column_reg, column_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W:0]   x_ext, y_ext, w_ext, h_ext;
    logic [POS_W:0]   k_ext;
    logic             band_row;
    logic             in_corner_rows;

    assign x_ext = {1'b0, column_reg};
    assign y_ext = {1'b0, row_reg};
    assign w_ext = {1'b0, frame_width};
    assign h_ext = {1'b0, frame_height};

    // right-side column counted from the scan window start toward the frame edge
    assign k_ext = x_ext + SCAN_EXT - w_ext;

    assign band_row       = (y_ext >= BAND_LO) && (y_ext < BAND_HI);
    assign in_corner_rows = (y_ext < CORNER_R);

    always_comb
    begin
        flags.row_end      = (x_ext + ONE_EXT) >= w_ext;
        flags.frame_end    = flags.row_end && ((y_ext + ONE_EXT) >= h_ext);
        flags.left_band    = band_row && (x_ext < SCAN_EXT);
        flags.right_band   = band_row && (x_ext < w_ext) && ((x_ext + SCAN_EXT) >= w_ext);
        flags.corner_left  = in_corner_rows && (x_ext < CORNER_C);
        flags.corner_right = in_corner_rows && !(x_ext < CORNER_C)
                             && ((x_ext + CORNER_C) >= w_ext);
    end

    assign left_index  = flags.left_band  ? column_reg[IDX_W-1:0] : '0;
    assign right_index = flags.right_band ? k_ext[IDX_W-1:0]      : '0;

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (advance)
        begin
            if (flags.frame_end)
            begin
                column_next = '0;
                row_next    = '0;
            end
            else if (flags.row_end)
            begin
                column_next = '0;
                row_next    = row_reg + POS_W'(1);
            end
            else
            begin
                column_next = column_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    assign column_pos = column_reg;
    assign row_pos    = row_reg;

endmodule

/* rtl/rmdef_frame_stats.sv */
// mask decision, corner green sums, band count update and side/edge pick
`timescale 1ns / 1ps

module rmdef_frame_stats
    import rmdef_pkg::*;
#(
    parameter int SCAN_COLUMNS = DEF_SCAN_COLUMNS,
    parameter int IDX_W        = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [PIX_W-1:0]   red,
    input  logic [PIX_W-1:0]   green,
    input  logic [PIX_W-1:0]   blue,
    input  pix_flags_t         flags,
    input  logic [IDX_W-1:0]   left_index,
    input  logic [IDX_W-1:0]   right_index,
    input  logic [COUNT_W-1:0] left_count,
    input  logic [COUNT_W-1:0] right_count,
    input  logic [POS_W-1:0]   frame_width,
    output logic               left_wr_en,
    output logic               right_wr_en,
    output logic [COUNT_W-1:0] left_wr_data,
    output logic [COUNT_W-1:0] right_wr_data,
    output logic               clear,
    output logic               mask_bit,
    output logic               door_on_right,
    output logic [POS_W-1:0]   edge_column
);

    localparam logic [COUNT_W-1:0] THRESH = COUNT_W'(EDGE_THRESHOLD);

    logic [9:0]             total;
    logic [10:0]            five_red;
    logic                   mask;
    logic                   left_cross, right_cross;
    logic [GREEN_SUM_W:0]   left_sum, right_sum;
    logic [GREEN_SUM_W-1:0] left_green_upd, right_green_upd;
    logic                   left_found_upd, right_found_upd;
    logic [IDX_W-1:0]       left_idx_upd, right_idx_upd;
    logic                   right_side;
    logic [POS_W-1:0]       col;

    logic [GREEN_SUM_W-1:0] left_green_reg, left_green_next;
    logic [GREEN_SUM_W-1:0] right_green_reg, right_green_next;
    logic                   left_found_reg, left_found_next;
    logic                   right_found_reg, right_found_next;
    logic [IDX_W-1:0]       left_idx_reg, left_idx_next;
    logic [IDX_W-1:0]       right_idx_reg, right_idx_next;

    // red dominant when 5r > 2(r+g+b); black gives 0 > 0, so mask 1
    assign total    = 10'(red) + 10'(green) + 10'(blue);
    assign five_red = {1'b0, red, 2'b00} + 11'(red);
    assign mask     = !(five_red > {total, 1'b0});

    assign left_wr_en    = step && flags.left_band && !mask;
    assign right_wr_en   = step && flags.right_band && !mask;
    assign left_wr_data  = left_count + COUNT_W'(1);
    assign right_wr_data = right_count + COUNT_W'(1);
    assign left_cross    = left_wr_en && (left_count == THRESH);
    assign right_cross   = right_wr_en && (right_count == THRESH);

    // saturating corner sums, current pixel included
    assign left_sum  = {1'b0, left_green_reg} + (GREEN_SUM_W+1)'(green);
    assign right_sum = {1'b0, right_green_reg} + (GREEN_SUM_W+1)'(green);

    always_comb
    begin
        left_green_upd  = left_green_reg;
        right_green_upd = right_green_reg;
        if (flags.corner_left)
        begin
            left_green_upd = left_sum[GREEN_SUM_W] ? '1 : left_sum[GREEN_SUM_W-1:0];
        end
        else if (flags.corner_right)
        begin
            right_green_upd = right_sum[GREEN_SUM_W] ? '1 : right_sum[GREEN_SUM_W-1:0];
        end
    end

    // outermost-first search kept as running min (left) and max (right)
    always_comb
    begin
        left_found_upd  = left_found_reg || left_cross;
        left_idx_upd    = left_idx_reg;
        right_found_upd = right_found_reg || right_cross;
        right_idx_upd   = right_idx_reg;
        if (left_cross && (!left_found_reg || (left_index < left_idx_reg)))
        begin
            left_idx_upd = left_index;
        end
        if (right_cross && (!right_found_reg || (right_index > right_idx_reg)))
        begin
            right_idx_upd = right_index;
        end
    end

    assign right_side = !(right_green_upd > left_green_upd);

    always_comb
    begin
        col = '0;
        if (right_side)
        begin
            if (right_found_upd)
            begin
                col = frame_width - POS_W'(SCAN_COLUMNS) + POS_W'(right_idx_upd);
            end
        end
        else if (left_found_upd)
        begin
            col = POS_W'(left_idx_upd);
        end
    end

    assign clear         = step && flags.frame_end;
    assign mask_bit      = mask;
    assign door_on_right = flags.frame_end && right_side;
    assign edge_column   = flags.frame_end ? col : '0;

    always_comb
    begin
        left_green_next  = left_green_reg;
        right_green_next = right_green_reg;
        left_found_next  = left_found_reg;
        right_found_next = right_found_reg;
        left_idx_next    = left_idx_reg;
        right_idx_next   = right_idx_reg;
        if (step)
        begin
            if (flags.frame_end)
            begin
                left_green_next  = '0;
                right_green_next = '0;
                left_found_next  = 1'b0;
                right_found_next = 1'b0;
                left_idx_next    = '0;
                right_idx_next   = '0;
            end
            else
            begin
                left_green_next  = left_green_upd;
                right_green_next = right_green_upd;
                left_found_next  = left_found_upd;
                right_found_next = right_found_upd;
                left_idx_next    = left_idx_upd;
                right_idx_next   = right_idx_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_green_reg  <= '0;
            right_green_reg <= '0;
            left_found_reg  <= 1'b0;
            right_found_reg <= 1'b0;
            left_idx_reg    <= '0;
            right_idx_reg   <= '0;
        end
        else
        begin
            left_green_reg  <= left_green_next;
            right_green_reg <= right_green_next;
            left_found_reg  <= left_found_next;
            right_found_reg <= right_found_next;
            left_idx_reg    <= left_idx_next;
            right_idx_reg   <= right_idx_next;
        end
    end

endmodule

/* rtl/red_mask_door_edge_finder.sv */
// top level: pixel stage, count memories and result register of the edge finder
// a pixel taken into the pixel stage moves into the result register once that register is free
// throughput: one pixel per cycle while result_stall does not hold the stages; the band count is read
//   when a pixel is taken and written from the pixel stage, and a pixel is still taken while a finished
//   result waits if the pixel stage is free; reset (asynchronous, active low) zeroes position, corner
//   sums, band valid bits and handshake state and loads width 640, height 480; no clearing pass follows
`timescale 1ns / 1ps

`include "assert_macros.svh"

module red_mask_door_edge_finder
    import rmdef_pkg::*;
#(
    parameter int SCAN_COLUMNS = DEF_SCAN_COLUMNS,
    parameter int BAND_ROWS    = DEF_BAND_ROWS,
    parameter int CORNER_ROWS  = DEF_CORNER_ROWS,
    parameter int CORNER_COLS  = DEF_CORNER_COLS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  logic [PIX_W-1:0]     red,
    input  logic [PIX_W-1:0]     green,
    input  logic [PIX_W-1:0]     blue,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 mask_bit,
    output logic                 frame_done,
    output logic                 door_on_right,
    output logic [POS_W-1:0]     edge_column
);

    localparam int IDX_W = (SCAN_COLUMNS > 1) ? $clog2(SCAN_COLUMNS) : 1;

    logic [POS_W-1:0]   frame_width_reg, frame_height_reg;

    logic               pixel_accept;
    logic               result_accept;
    logic               res_ready;
    logic               a_step;
    logic               a_valid_reg, a_valid_next;
    logic               res_valid_reg, res_valid_next;

    pix_flags_t         pix_flags;
    logic [POS_W-1:0]   column_pos, row_pos;
    logic [IDX_W-1:0]   left_index, right_index;

    logic [PIX_W-1:0]   red_a_reg, green_a_reg, blue_a_reg;
    pix_flags_t         flags_a_reg;
    logic [IDX_W-1:0]   left_index_a_reg, right_index_a_reg;

    logic [COUNT_W-1:0] left_count, right_count;
    logic               left_wr_en, right_wr_en;
    logic [COUNT_W-1:0] left_wr_data, right_wr_data;
    logic               clear;
    logic               mask_a;
    logic               door_a;
    logic [POS_W-1:0]   edge_a;

    logic               mask_bit_reg, frame_done_reg, door_reg;
    logic [POS_W-1:0]   edge_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data;
            end
            else if (cfg_index == CFG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    // handshake
    assign res_ready     = !res_valid_reg || !result_stall;
    assign a_step        = a_valid_reg && res_ready;
    assign pixel_stall   = a_valid_reg && !res_ready;
    assign pixel_accept  = pixel_valid && !pixel_stall;
    assign result_accept = res_valid_reg && !result_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (pixel_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_step)
        begin
            a_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (a_step)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_accept)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    rmdef_raster_pos #(
        .SCAN_COLUMNS (SCAN_COLUMNS),
        .BAND_ROWS    (BAND_ROWS),
        .CORNER_ROWS  (CORNER_ROWS),
        .CORNER_COLS  (CORNER_COLS),
        .IDX_W        (IDX_W)
    ) u_raster_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (pixel_accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .flags        (pix_flags),
        .column_pos   (column_pos),
        .row_pos      (row_pos),
        .left_index   (left_index),
        .right_index  (right_index)
    );

    // pixel stage
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            red_a_reg         <= red;
            green_a_reg       <= green;
            blue_a_reg        <= blue;
            flags_a_reg       <= pix_flags;
            left_index_a_reg  <= left_index;
            right_index_a_reg <= right_index;
        end
    end

    rmdef_count_mem #(
        .DEPTH   (SCAN_COLUMNS),
        .ADDR_W  (IDX_W),
        .DATA_W  (COUNT_W)
    ) u_left_counts (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pixel_accept),
        .rd_addr (left_index),
        .wr_en   (left_wr_en),
        .wr_addr (left_index_a_reg),
        .wr_data (left_wr_data),
        .clear   (clear),
        .rd_data (left_count)
    );

    rmdef_count_mem #(
        .DEPTH   (SCAN_COLUMNS),
        .ADDR_W  (IDX_W),
        .DATA_W  (COUNT_W)
    ) u_right_counts (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pixel_accept),
        .rd_addr (right_index),
        .wr_en   (right_wr_en),
        .wr_addr (right_index_a_reg),
        .wr_data (right_wr_data),
        .clear   (clear),
        .rd_data (right_count)
    );

    rmdef_frame_stats #(
        .SCAN_COLUMNS  (SCAN_COLUMNS),
        .IDX_W         (IDX_W)
    ) u_frame_stats (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (a_step),
        .red           (red_a_reg),
        .green         (green_a_reg),
        .blue          (blue_a_reg),
        .flags         (flags_a_reg),
        .left_index    (left_index_a_reg),
        .right_index   (right_index_a_reg),
        .left_count    (left_count),
        .right_count   (right_count),
        .frame_width   (frame_width_reg),
        .left_wr_en    (left_wr_en),
        .right_wr_en   (right_wr_en),
        .left_wr_data  (left_wr_data),
        .right_wr_data (right_wr_data),
        .clear         (clear),
        .mask_bit      (mask_a),
        .door_on_right (door_a),
        .edge_column   (edge_a)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (a_step)
        begin
            mask_bit_reg   <= mask_a;
            frame_done_reg <= flags_a_reg.frame_end;
            door_reg       <= door_a;
            edge_reg       <= edge_a;
        end
    end

    assign result_valid  = res_valid_reg;
    assign mask_bit      = mask_bit_reg;
    assign frame_done    = frame_done_reg;
    assign door_on_right = door_reg;
    assign edge_column   = edge_reg;

    `RMDEF_ASSERT(a_side_only_at_end,
        (result_valid && !frame_done) |-> (!door_on_right && (edge_column == '0)),
        "side or column reported before frame end")
    `RMDEF_ASSERT(a_pos_wraps,
        (pixel_accept && pix_flags.frame_end) |=> ((column_pos == '0) && (row_pos == '0)),
        "position not reset after last pixel")
    `RMDEF_ASSERT_NEVER(a_empty_stage_stall, !a_valid_reg && pixel_stall,
        "pixel stalled with empty pixel stage")

endmodule

/* sim/tb_red_mask_door_edge_finder.sv */
// testbench of the red mask door edge finder: random frames checked against a local predictor
`timescale 1ns / 1ps

module tb_red_mask_door_edge_finder;
    import rmdef_pkg::*;

    localparam int SCAN_COLS   = DEF_SCAN_COLUMNS;
    localparam int CORNER_ROWS = DEF_CORNER_ROWS;
    localparam int CORNER_COLS = DEF_CORNER_COLS;
    localparam int BAND_END    = BAND_START_ROW + DEF_BAND_ROWS;
    localparam int GREEN_MAX   = (1 << GREEN_SUM_W) - 1;
    localparam int NO_DOOR     = DEF_SCAN_COLUMNS;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int MAX_REPORTS = 10;

    // indexes past the two registers, which the block ignores
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] r, g, b;
    } rgb_t;

    typedef struct packed {
        logic             mask;
        logic             done;
        logic             right;
        logic [POS_W-1:0] col;
    } pixel_result_t;

    typedef enum {GREEN_EVEN, GREEN_LEFT, GREEN_RIGHT, GREEN_RANDOM} corner_bias_t;

    // inward distance from each edge at which the band turns mostly red
    typedef struct {
        int           left_d;
        int           right_d;
        corner_bias_t bias;
        bit           noise;
    } frame_plan_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [POS_W-1:0]     cfg_data;
    logic                 pixel_valid;
    logic                 pixel_stall;
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic                 result_valid;
    logic                 result_stall;
    logic                 mask_bit;
    logic                 frame_done;
    logic                 door_on_right;
    logic [POS_W-1:0]     edge_column;

    red_mask_door_edge_finder dut (.*);

    always #4 clk = ~clk;

    // predictor state
    logic [POS_W-1:0]       width_cfg;
    logic [POS_W-1:0]       height_cfg;
    logic [POS_W-1:0]       col_pos;
    logic [POS_W-1:0]       row_pos;
    logic [GREEN_SUM_W-1:0] left_green;
    logic [GREEN_SUM_W-1:0] right_green;
    logic [7:0]             left_hits [SCAN_COLS];
    logic [7:0]             right_hits [SCAN_COLS];
    bit                     frame_closed;

    pixel_result_t awaited_results [$];

    bit send_idle_on;
    bit stall_idle_on;
    int hold_cycles;
    int error_count;
    int pixels_sent;
    int results_checked;
    int frames_seen;
    int right_frames;
    int edge_frames;
    int watchdog_cycles;

    function automatic logic [GREEN_SUM_W-1:0] sat_add(logic [GREEN_SUM_W-1:0] acc,
                                                       logic [PIX_W-1:0] val);
        int unsigned s;
        s = acc + val;
        return (s > GREEN_MAX) ? GREEN_MAX[GREEN_SUM_W-1:0] : s[GREEN_SUM_W-1:0];
    endfunction

    function automatic void clear_frame_state();
        col_pos     = '0;
        row_pos     = '0;
        left_green  = '0;
        right_green = '0;
        foreach (left_hits[i])
        begin
            left_hits[i]  = '0;
            right_hits[i] = '0;
        end
    endfunction

    // works out the result of one accepted pixel and moves the frame state on
    task automatic score_pixel(rgb_t px);
        int unsigned   x, y, w, rv, gv, total, k;
        int            i;
        bit            row_end;
        pixel_result_t res;
        x     = col_pos;
        y     = row_pos;
        w     = width_cfg;
        rv    = px.r;
        gv    = px.g;
        total = rv + gv + px.b;
        res   = '0;
        res.mask = (total != 0 && 5 * rv > 2 * total) ? 1'b0 : 1'b1;

        if (y < CORNER_ROWS)
        begin
            if (x < CORNER_COLS)
                left_green = sat_add(left_green, px.g);
            else if (x + CORNER_COLS >= w)
                right_green = sat_add(right_green, px.g);
        end

        if (!res.mask && y >= BAND_START_ROW && y < BAND_END)
        begin
            if (x < SCAN_COLS)
                left_hits[x]++;
            if (x < w && x + SCAN_COLS >= w)
            begin
                k = x + SCAN_COLS - w;
                if (k < SCAN_COLS)
                    right_hits[k]++;
            end
        end

        row_end  = (x + 1 >= w);
        res.done = row_end && (y + 1 >= height_cfg);

        if (res.done)
        begin
            res.right = !(right_green > left_green);
            if (res.right)
            begin
                for (i = SCAN_COLS - 1; i >= 0; i--)
                begin
                    if (right_hits[i] > EDGE_THRESHOLD)
                    begin
                        res.col = POS_W'(w - SCAN_COLS + i);
                        break;
                    end
                end
            end
            else
            begin
                for (i = 0; i < SCAN_COLS; i++)
                begin
                    if (left_hits[i] > EDGE_THRESHOLD)
                    begin
                        res.col = POS_W'(i);
                        break;
                    end
                end
            end
            clear_frame_state();
        end
        else if (row_end)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end

        frame_closed = res.done;
        awaited_results.push_back(res);
    endtask

    function automatic rgb_t any_pixel();
        rgb_t px;
        px.r = PIX_W'($urandom_range(0, 255));
        px.g = PIX_W'($urandom_range(0, 255));
        px.b = PIX_W'($urandom_range(0, 255));
        return px;
    endfunction

    // green and blue kept below half the red, so always red-dominant
    function automatic rgb_t red_pixel();
        rgb_t px;
        px.r = PIX_W'($urandom_range(120, 255));
        px.g = PIX_W'($urandom_range(0, px.r / 4));
        px.b = PIX_W'($urandom_range(0, px.r / 4));
        return px;
    endfunction

    // green and blue at least the red, so never red-dominant
    function automatic rgb_t plain_pixel();
        rgb_t px;
        px.r = PIX_W'($urandom_range(0, 200));
        px.g = PIX_W'($urandom_range(px.r, 255));
        px.b = PIX_W'($urandom_range(px.r, 255));
        return px;
    endfunction

    // content of the next pixel, placed by the predictor's current position
    function automatic rgb_t gen_pixel(frame_plan_t plan);
        int               x, y, w, chance;
        bit               in_left;
        logic [PIX_W-1:0] hi_green, lo_green;
        rgb_t             px;
        x  = col_pos;
        y  = row_pos;
        w  = width_cfg;
        px = any_pixel();
        if (plan.noise)
            return px;
        if (y < CORNER_ROWS)
        begin
            in_left = (x < CORNER_COLS);
            if (in_left || x + CORNER_COLS >= w)
            begin
                hi_green = PIX_W'($urandom_range(150, 255));
                lo_green = PIX_W'($urandom_range(0, 90));
                case (plan.bias)
                    GREEN_EVEN:  px.g = '0;
                    GREEN_LEFT:  px.g = in_left ? hi_green : lo_green;
                    GREEN_RIGHT: px.g = in_left ? lo_green : hi_green;
                    default:     ;
                endcase
            end
        end
        else if (y >= BAND_START_ROW && y < BAND_END)
        begin
            chance = 20;
            if (x < SCAN_COLS && x >= plan.left_d)
                chance = 90;
            if (x + SCAN_COLS >= w && w - 1 - x >= plan.right_d)
                chance = 90;
            px = ($urandom_range(1, 100) <= chance) ? red_pixel() : plain_pixel();
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            px = plain_pixel();
        end
        return px;
    endfunction

    function automatic frame_plan_t random_plan();
        frame_plan_t plan;
        plan.left_d  = $urandom_range(0, NO_DOOR);
        plan.right_d = $urandom_range(0, NO_DOOR);
        plan.bias    = corner_bias_t'($urandom_range(0, 3));
        plan.noise   = ($urandom_range(0, 9) == 0);
        return plan;
    endfunction

    // one pixel transaction, with an occasional idle burst in front of it
    task automatic send_pixel(rgb_t px);
        int gap;
        if (send_idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            pixel_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        red         <= px.r;
        green       <= px.g;
        blue        <= px.b;
        do @(posedge clk); while (pixel_stall);
        score_pixel(px);
        pixels_sent++;
    endtask

    // registers only change once every pixel in flight has come out
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [POS_W-1:0] value);
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (index == CFG_FRAME_WIDTH)
            width_cfg = value;
        else if (index == CFG_FRAME_HEIGHT)
            height_cfg = value;
    endtask

    task automatic set_geometry(int w, int h);
        write_reg(CFG_FRAME_WIDTH, POS_W'(w));
        write_reg(CFG_FRAME_HEIGHT, POS_W'(h));
    endtask

    task automatic run_frame(frame_plan_t plan);
        do send_pixel(gen_pixel(plan)); while (!frame_closed);
    endtask

    // colour extremes and the ratio right at and just past 0.4, at the reset geometry
    task automatic test_pixel_extremes();
        rgb_t probes [18];
        probes = '{'{8'd0, 8'd0, 8'd0},     '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
                   '{8'd0, 8'd255, 8'd0},   '{8'd0, 8'd0, 8'd255},     '{8'd200, 8'd150, 8'd150},
                   '{8'd2, 8'd3, 8'd0},     '{8'd201, 8'd150, 8'd150}, '{8'd1, 8'd0, 8'd0},
                   '{8'd0, 8'd0, 8'd1},     '{8'd255, 8'd254, 8'd0},   '{8'd128, 8'd127, 8'd0},
                   '{8'd100, 8'd75, 8'd75}, '{8'd85, 8'd0, 8'd128},    '{8'd86, 8'd0, 8'd128},
                   '{8'd170, 8'd85, 8'd170}, '{8'd1, 8'd1, 8'd0},      '{8'd127, 8'd128, 8'd255}};
        foreach (probes[i])
            send_pixel(probes[i]);
    endtask

    // ignored indexes, largest geometry mid-frame, a short frame past both corners, then
    // a narrow frame with the door on the outermost left column
    task automatic test_register_extremes();
        frame_plan_t noise_plan;
        frame_plan_t corner_right;
        frame_plan_t outer_left;
        noise_plan   = '{left_d: NO_DOOR, right_d: NO_DOOR, bias: GREEN_RANDOM, noise: 1'b1};
        corner_right = '{left_d: NO_DOOR, right_d: NO_DOOR, bias: GREEN_RIGHT, noise: 1'b0};
        outer_left   = '{left_d: 0, right_d: NO_DOOR, bias: GREEN_LEFT, noise: 1'b0};
        write_reg(CFG_SPARE_A, 12'hfff);
        write_reg(CFG_SPARE_B, 12'h000);
        set_geometry(4095, 4095);
        repeat (100) send_pixel(gen_pixel(noise_plan));
        // the column is already past the new width, so the row ends at once
        set_geometry(24, 3);
        run_frame(corner_right);
        // door on the outermost left column, which reads the same as no door
        set_geometry(5, 70);
        run_frame(outer_left);
    endtask

    // narrow frames: both bands overlap and all corner pixels go to the left
    task automatic test_door_frames();
        repeat (2)
        begin
            set_geometry($urandom_range(3, 5), $urandom_range(70, 72));
            run_frame(random_plan());
        end
    endtask

    // equal corner sums pick the right side; the frame stops inside the band, so no column
    // passes the threshold
    task automatic test_tie_no_door();
        set_geometry(3, 60);
        run_frame('{left_d: NO_DOOR, right_d: NO_DOOR, bias: GREEN_EVEN, noise: 1'b0});
    endtask

    // the receiver holds off long enough for the block to stall its input
    task automatic test_result_backpressure();
        frame_plan_t plan;
        int          count;
        plan  = '{left_d: $urandom_range(0, NO_DOOR), right_d: 0, bias: GREEN_RIGHT, noise: 1'b0};
        count = 0;
        set_geometry(4, 70);
        do
        begin
            send_pixel(gen_pixel(plan));
            count++;
            if (count == 60 || count == 200)
                hold_cycles = 400;
        end
        while (!frame_closed);
    endtask

    task automatic test_streaming();
        frame_plan_t plan;
        plan       = random_plan();
        plan.noise = 1'b0;
        send_idle_on  = 1'b0;
        stall_idle_on = 1'b0;
        set_geometry(3, 70);
        run_frame(plan);
    endtask

    // receiver side: random stall bursts plus the long hold-off
    initial
    begin
        int burst;
        burst = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_cycles--;
            end
            else if (burst > 0)
            begin
                result_stall <= 1'b1;
                burst--;
            end
            else if (stall_idle_on && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                burst = $urandom_range(1, 11) - 1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // every accepted result transaction against the oldest prediction
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (awaited_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: mask %0b done %0b right %0b column %0d",
                             mask_bit, frame_done, door_on_right, edge_column);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (mask_bit !== want.mask || frame_done !== want.done ||
                    door_on_right !== want.right || edge_column !== want.col)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("result %0d: expected mask %0b done %0b right %0b column %0d,",
                                 results_checked, want.mask, want.done, want.right, want.col,
                                 " got mask %0b done %0b right %0b column %0d",
                                 mask_bit, frame_done, door_on_right, edge_column);
                end
                if (want.done)
                begin
                    frames_seen++;
                    if (want.right)
                        right_frames++;
                    if (want.col != 0)
                        edge_frames++;
                end
            end
        end
    end

    initial
    begin
        for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_FRAME_WIDTH;
        cfg_data     = '0;
        pixel_valid  = 1'b0;
        red          = '0;
        green        = '0;
        blue         = '0;
        width_cfg    = WIDTH_RESET;
        height_cfg   = HEIGHT_RESET;
        clear_frame_state();
        frame_closed  = 1'b0;
        send_idle_on  = 1'b1;
        stall_idle_on = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pixel_extremes();
        test_register_extremes();
        test_door_frames();
        test_tie_no_door();
        test_result_backpressure();
        test_streaming();

        @(negedge clk);
        pixel_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d pixels in %0d finished frames (%0d on the right side, %0d left)",
                 pixels_sent, frames_seen, right_frames, frames_seen - right_frames);
        $display("%0d frames reported an edge column, %0d results checked, %0d mismatches",
                 edge_frames, results_checked, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
